### hdl/stds_pkg.sv
// Shared types and constants for the scope trace decimate and scale block.
package stds_pkg;

  localparam int unsigned VOLT_W          = 16;
  localparam int unsigned HEIGHT_W        = 12;
  localparam int unsigned NSAMP_W         = 16;
  localparam int unsigned NDOTS_W         = 13;
  localparam int unsigned ROW_W           = 16;
  localparam int unsigned DOT_IDX_W       = 12;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned ACC_W           = 30;
  localparam int unsigned PER_ITEM_W      = 7;
  localparam int unsigned MAX_PER_ITEM    = 64;
  localparam int unsigned QUOT_W          = 16;
  localparam int unsigned DEN_W           = 17;

  localparam int unsigned MAX_DOTS_DEF    = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam logic signed [VOLT_W-1:0]   VOLT_MIN_RST   = 16'sh8000;
  localparam logic signed [VOLT_W-1:0]   VOLT_MAX_RST   = 16'sh7FFF;
  localparam logic        [HEIGHT_W-1:0] HEIGHT_RST     = 12'd480;
  localparam logic        [NSAMP_W-1:0]  NUM_SAMPLES_RST = 16'd1024;
  localparam logic        [NDOTS_W-1:0]  NUM_DOTS_RST   = 13'd1024;

  localparam logic signed [ROW_W-1:0] ROW_SAT_HI = 16'sh7FFF;
  localparam logic signed [ROW_W-1:0] ROW_SAT_LO = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_MIN      = 3'd0,
    CFG_VOLT_MAX      = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_NUM_SAMPLES   = 3'd3,
    CFG_NUM_DOTS      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VOLT_W-1:0] volt_min;
    logic signed [VOLT_W-1:0] volt_max;
    logic [HEIGHT_W-1:0]      screen_height;
  } row_cfg_t;

endpackage

### hdl/stds_row_unit.sv
// Iterative row scaler: one multiply, then a shared restoring divider with floor and saturation.
module stds_row_unit #(
  parameter int unsigned SAMPLE_BITS = stds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  stds_pkg::row_cfg_t               cfg_i,
  output logic                             done_o,
  output logic signed [stds_pkg::ROW_W-1:0] row_o
);
  import stds_pkg::*;

  localparam int unsigned DIFF_W = ((SAMPLE_BITS > VOLT_W) ? SAMPLE_BITS : VOLT_W) + 1;
  localparam int unsigned NUM_W  = DIFF_W + HEIGHT_W + 1;
  localparam int unsigned CMP_W  = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
  localparam int unsigned CNT_W  = $clog2(QUOT_W);

  typedef enum logic [4:0] {
    RU_IDLE = 5'b00001,
    RU_MUL  = 5'b00010,
    RU_PREP = 5'b00100,
    RU_DIV  = 5'b01000,
    RU_FIX  = 5'b10000
  } ru_state_e;

  ru_state_e                  state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [NUM_W-1:0]    num_q;
  logic signed [DEN_W-1:0]    den_q;
  logic [DEN_W-1:0]           dmag_q;
  logic [DEN_W-1:0]           rem_q;
  logic [QUOT_W-1:0]          low_q;
  logic [QUOT_W-1:0]          quot_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       neg_q;
  logic                       done_q;
  logic signed [ROW_W-1:0]    row_q;

  logic [NUM_W-1:0]           num_mag;
  logic [DEN_W-1:0]           den_mag;
  logic                       ovf;
  logic                       neg;
  logic [DEN_W:0]             trial;
  logic                       fits;
  logic [QUOT_W:0]            neg_mag;
  logic signed [DIFF_W-1:0]   diff;

  assign diff    = DIFF_W'(cfg_i.volt_max) - DIFF_W'(sample_q);
  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign den_mag = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
  assign ovf     = CMP_W'(num_mag) >= CMP_W'({den_mag, {QUOT_W{1'b0}}});
  assign neg     = num_q[NUM_W-1] ^ den_q[DEN_W-1];
  assign trial   = {rem_q, low_q[QUOT_W-1]};
  assign fits    = trial >= {1'b0, dmag_q};
  assign neg_mag = {1'b0, quot_q} + {{QUOT_W{1'b0}}, (rem_q != '0)};

  always_comb begin
    state_d = state_q;
    case (state_q)
      RU_IDLE: if (start_i) state_d = RU_MUL;
      RU_MUL:  state_d = RU_PREP;
      RU_PREP: begin
        if (den_q == '0 || ovf) begin
          state_d = RU_IDLE;
        end else begin
          state_d = RU_DIV;
        end
      end
      RU_DIV:  if (cnt_q == CNT_W'(QUOT_W - 1)) state_d = RU_FIX;
      RU_FIX:  state_d = RU_IDLE;
      default: state_d = RU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == RU_FIX) ||
                 ((state_q == RU_PREP) && (den_q == '0 || ovf));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      RU_IDLE: begin
        if (start_i) sample_q <= sample_i;
      end
      RU_MUL: begin
        num_q <= NUM_W'($signed({1'b0, cfg_i.screen_height})) * NUM_W'(diff);
        den_q <= DEN_W'(cfg_i.volt_max) - DEN_W'(cfg_i.volt_min);
      end
      RU_PREP: begin
        dmag_q <= den_mag;
        rem_q  <= DEN_W'(num_mag >> QUOT_W);
        low_q  <= num_mag[QUOT_W-1:0];
        quot_q <= '0;
        cnt_q  <= '0;
        neg_q  <= neg;
        if (den_q == '0) begin
          row_q <= '0;
        end else if (ovf) begin
          row_q <= neg ? ROW_SAT_LO : ROW_SAT_HI;
        end
      end
      RU_DIV: begin
        rem_q  <= fits ? DEN_W'(trial - {1'b0, dmag_q}) : DEN_W'(trial);
        low_q  <= {low_q[QUOT_W-2:0], 1'b0};
        quot_q <= {quot_q[QUOT_W-2:0], fits};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      RU_FIX: begin
        if (neg_q) begin
          if (neg_mag > (QUOT_W+1)'(32768)) begin
            row_q <= ROW_SAT_LO;
          end else begin
            row_q <= ROW_W'((QUOT_W+1)'(0) - neg_mag);
          end
        end else if (quot_q > QUOT_W'(32767)) begin
          row_q <= ROW_SAT_HI;
        end else begin
          row_q <= $signed(quot_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign row_o  = row_q;

endmodule

### hdl/scope_trace_decimate_scale.sv
// Top level of the scope trace decimator with linear display scaling.
//
// Samples of one channel arrive on the slave stream: tdata carries the signed
// sample and tuser the frame-start flag, which restarts the trace at that item.
// Each accepted item that falls inside the trace is scaled to a screen row by
// the row unit: one multiply, a sign and range check, then a 16-step restoring
// division, skipped for a zero span or a saturated row. The item then yields
// zero to 64 dots, one per cycle while the receiver keeps taking them; tlast
// marks the final dot of the trace. An item past the trace or after its final
// dot is taken and gives no dots. The slave side is ready only between items,
// so a new item is not taken before the current one is through.
// A dot sits in the output register until taken, so a stalled receiver holds
// up the dot loop but not the acceptance of the next item once the current
// one is finished.
// Configuration writes are always accepted and should be made between items.
// Reset loads the default scaling registers and clears the trace counters.
module scope_trace_decimate_scale #(
  parameter int unsigned MAX_DOTS    = stds_pkg::MAX_DOTS_DEF,
  parameter int unsigned SAMPLE_BITS = stds_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [S_TDATA_W-1:0]                s_axis_tdata,  // sample
  input  logic [0:0]                          s_axis_tuser,  // frame_start
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,  // pixel_row, dot_index
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stds_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import stds_pkg::*;

  localparam logic [NDOTS_W-1:0] DOT_CAP =
    NDOTS_W'((MAX_DOTS > 8191) ? 8191 : MAX_DOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROW  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  row_cfg_t               row_cfg_q;
  logic [NSAMP_W-1:0]     num_samples_q;
  logic [NDOTS_W-1:0]     num_dots_q;
  logic [NSAMP_W-1:0]     sample_count_q;
  logic [NDOTS_W-1:0]     dot_count_q;
  logic [ACC_W-1:0]       acc_q;
  logic [ACC_W-1:0]       limit_q;
  logic                   trace_done_q;
  logic [PER_ITEM_W-1:0]  n_q;
  logic                   m_valid_q;
  logic signed [ROW_W-1:0] m_row_q;
  logic [DOT_IDX_W-1:0]   m_idx_q;
  logic                   m_last_q;

  logic                   in_acc;
  logic                   fs;
  logic                   skip;
  logic                   row_start;
  logic                   row_done;
  logic signed [ROW_W-1:0] row;
  logic [NDOTS_W-1:0]     ndots;
  logic                   more;
  logic                   out_free;
  logic                   load;
  logic                   is_last;

  assign ndots     = (num_dots_q > DOT_CAP) ? DOT_CAP : num_dots_q;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign fs        = s_axis_tuser[0];
  assign skip      = fs ? (num_samples_q == '0)
                        : (trace_done_q || sample_count_q >= num_samples_q);
  assign row_start = in_acc && !skip;
  assign more      = (n_q < PER_ITEM_W'(MAX_PER_ITEM)) && (dot_count_q < ndots) &&
                     (acc_q < limit_q);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign load      = (state_q == ST_EMIT) && more && out_free;
  assign is_last   = (dot_count_q + NDOTS_W'(1)) == ndots;

  stds_row_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (row_start),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_i    (row_cfg_q),
    .done_o   (row_done),
    .row_o    (row)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (row_start) state_d = ST_ROW;
      ST_ROW:  if (row_done) state_d = ST_EMIT;
      ST_EMIT: if (!more) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_cfg_q      <= '{volt_min: VOLT_MIN_RST, volt_max: VOLT_MAX_RST,
                          screen_height: HEIGHT_RST};
      num_samples_q  <= NUM_SAMPLES_RST;
      num_dots_q     <= NUM_DOTS_RST;
      sample_count_q <= '0;
      dot_count_q    <= '0;
      acc_q          <= '0;
      limit_q        <= '0;
      trace_done_q   <= 1'b0;
      n_q            <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_VOLT_MIN:      row_cfg_q.volt_min      <= $signed(cfg_data_i);
          CFG_VOLT_MAX:      row_cfg_q.volt_max      <= $signed(cfg_data_i);
          CFG_SCREEN_HEIGHT: row_cfg_q.screen_height <= cfg_data_i[HEIGHT_W-1:0];
          CFG_NUM_SAMPLES:   num_samples_q           <= cfg_data_i;
          CFG_NUM_DOTS:      num_dots_q              <= cfg_data_i[NDOTS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && fs) begin
        sample_count_q <= '0;
        dot_count_q    <= '0;
        acc_q          <= '0;
        trace_done_q   <= 1'b0;
      end
      if (row_start) begin
        n_q <= '0;
      end
      if (state_q == ST_ROW) begin
        limit_q <= ACC_W'({1'b0, sample_count_q} + (NSAMP_W+1)'(1)) * ACC_W'(ndots);
      end
      if (load) begin
        dot_count_q <= dot_count_q + NDOTS_W'(1);
        acc_q       <= acc_q + ACC_W'(num_samples_q);
        n_q         <= n_q + PER_ITEM_W'(1);
        if (is_last) trace_done_q <= 1'b1;
      end
      if ((state_q == ST_EMIT) && !more) begin
        sample_count_q <= sample_count_q + NSAMP_W'(1);
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_row_q  <= row;
      m_idx_q  <= dot_count_q[DOT_IDX_W-1:0];
      m_last_q <= is_last;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, m_idx_q, m_row_q};
  assign m_axis_tlast  = m_last_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking testbench for scope_trace_decimate_scale: directed and random traces.
module testbench;
  import stds_pkg::*;

  typedef struct {
    logic signed [ROW_W-1:0] row;
    logic [DOT_IDX_W-1:0]    idx;
    logic                    last;
  } screen_dot_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic signed [VOLT_W-1:0] cur_vmin   = VOLT_MIN_RST;
  logic signed [VOLT_W-1:0] cur_vmax   = VOLT_MAX_RST;
  logic [HEIGHT_W-1:0]      cur_height = HEIGHT_RST;
  logic [NSAMP_W-1:0]       cur_nsamp  = NUM_SAMPLES_RST;
  logic [NDOTS_W-1:0]       cur_ndots  = NUM_DOTS_RST;

  int unsigned trace_samples  = 0;
  int unsigned trace_dots     = 0;
  longint      pick_acc       = 0;
  bit          trace_finished = 1'b0;

  screen_dot_t pending_dots[$];
  screen_dot_t want_dot;

  bit calm         = 1'b0;
  int ready_hold   = 0;
  int mismatches   = 0;
  int items_used   = 0;
  int dots_checked = 0;
  int cfg_sets     = 0;

  scope_trace_decimate_scale i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [ROW_W-1:0] scale_row(input logic signed [VOLT_W-1:0] v);
    longint span, prod, q;
    span = longint'(cur_vmax) - longint'(cur_vmin);
    if (span == 0) return '0;
    prod = longint'(cur_height) * (longint'(cur_vmax) - longint'(v));
    q = prod / span;
    if ((prod % span) != 0 && ((prod < 0) != (span < 0))) q--;
    if (q > longint'(ROW_SAT_HI)) q = longint'(ROW_SAT_HI);
    if (q < longint'(ROW_SAT_LO)) q = longint'(ROW_SAT_LO);
    return q[ROW_W-1:0];
  endfunction

  // Returns the number of dots the sample yields, or -1 when it falls outside the trace.
  task automatic decimate_sample(input logic signed [VOLT_W-1:0] smp, input logic fs,
                                 output int n);
    int unsigned ndots;
    longint limit;
    screen_dot_t d;
    n = -1;
    ndots = (cur_ndots > MAX_DOTS_DEF) ? MAX_DOTS_DEF : cur_ndots;
    if (fs) begin
      trace_samples = 0;
      trace_dots = 0;
      pick_acc = 0;
      trace_finished = 1'b0;
    end
    if (trace_finished || trace_samples >= cur_nsamp) return;
    n = 0;
    d.row = scale_row(smp);
    limit = longint'(trace_samples + 1) * longint'(ndots);
    while (n < MAX_PER_ITEM && trace_dots < ndots && pick_acc < limit) begin
      d.idx = trace_dots[DOT_IDX_W-1:0];
      d.last = (trace_dots + 1 == ndots);
      pending_dots.push_back(d);
      n++;
      trace_dots++;
      pick_acc += cur_nsamp;
      if (d.last) trace_finished = 1'b1;
    end
    trace_samples++;
  endtask

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic send_sample(input logic signed [VOLT_W-1:0] smp, input logic fs);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= fs;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    decimate_sample(smp, fs, n);
    if (n >= 0) items_used++;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    case (idx)
      CFG_VOLT_MIN:      cur_vmin = val;
      CFG_VOLT_MAX:      cur_vmax = val;
      CFG_SCREEN_HEIGHT: cur_height = val[HEIGHT_W-1:0];
      CFG_NUM_SAMPLES:   cur_nsamp = val;
      CFG_NUM_DOTS:      cur_ndots = val[NDOTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic signed [VOLT_W-1:0] vmin, input logic signed [VOLT_W-1:0] vmax,
                           input logic [HEIGHT_W-1:0] h, input logic [NSAMP_W-1:0] ns,
                           input logic [NDOTS_W-1:0] nd);
    cfg_write(CFG_VOLT_MIN, vmin);
    cfg_write(CFG_VOLT_MAX, vmax);
    cfg_write(CFG_SCREEN_HEIGHT, 16'(h));
    cfg_write(CFG_NUM_SAMPLES, ns);
    cfg_write(CFG_NUM_DOTS, 16'(nd));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_sets++;
  endtask

  // Samples outside the trace give no dots, so the block may still be busy after the last dot.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_sample(VOLT_MIN_RST, 1'b0);
    send_sample(VOLT_MAX_RST, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    drain();
  endtask

  task automatic test_row_scaling();
    apply_cfg(-16'sd100, 16'sd100, 12'hFFF, 16'd8, 13'd8);
    send_sample(VOLT_MAX_RST, 1'b1);
    send_sample(VOLT_MIN_RST, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    drain();
    apply_cfg(16'sd5, 16'sd5, 12'd1, 16'd4, 13'd4);
    send_sample(16'sd5, 1'b1);
    send_sample(VOLT_MIN_RST, 1'b0);
    drain();
    apply_cfg(16'sd1000, -16'sd1000, 12'd1, 16'd4, 13'd4);
    send_sample(16'sd999, 1'b1);
    send_sample(-16'sd1001, 1'b0);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd0, 16'd4, 13'd4);
    send_sample(16'sd1234, 1'b1);
    drain();
  endtask

  task automatic test_trace_bounds();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'hFFF, 16'd3, 13'd3);
    send_sample(16'sd10, 1'b1);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd30, 1'b0);
    send_sample(16'sd40, 1'b0);
    send_sample(16'sd50, 1'b1);
    send_sample(16'sd60, 1'b1);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd480, 16'd2, 13'd200);
    send_sample(-16'sd7, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd9, 1'b0);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd480, 16'hFFFF, 13'h1FFF);
    send_sample(16'sd3, 1'b1);
    send_sample(16'sd4, 1'b0);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd480, 16'd0, 13'd1);
    send_sample(16'sd1, 1'b1);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd480, 16'd1, 13'd0);
    send_sample(16'sd2, 1'b1);
    drain();
    apply_cfg(VOLT_MIN_RST, VOLT_MAX_RST, 12'd480, 16'd1, 13'd1);
    send_sample(16'sd3, 1'b1);
    drain();
  endtask

  task automatic test_random_traces();
    logic signed [VOLT_W-1:0] lo, hi, smp;
    logic [HEIGHT_W-1:0] h;
    logic [NSAMP_W-1:0] ns;
    logic [NDOTS_W-1:0] nd;
    int start, span_lo, span_hi, len;
    logic fs;
    start = items_used;
    while (items_used - start < 60) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
      case ($urandom_range(0, 7))
        0: hi = lo;
        1: hi = lo + 16'($urandom_range(1, 64));
        2: begin
          lo = VOLT_MIN_RST;
          hi = VOLT_MAX_RST;
        end
        default: ;
      endcase
      h = ($urandom_range(0, 4) == 0) ? 12'hFFF : 12'($urandom_range(1, 4095));
      ns = 16'($urandom_range(1, 20));
      case ($urandom_range(0, 9))
        0: nd = 13'($urandom_range(1, 8191));
        1: nd = 13'(64 * ns + $urandom_range(1, 40));
        2: nd = 13'(ns);
        default: nd = 13'($urandom_range(1, 4 * ns));
      endcase
      apply_cfg(lo, hi, h, ns, nd);
      span_lo = (lo < hi) ? int'(lo) : int'(hi);
      span_hi = (lo < hi) ? int'(hi) : int'(lo);
      repeat ($urandom_range(1, 3)) begin
        len = int'(ns) + int'($urandom_range(0, 2));
        for (int k = 0; k < len; k++) begin
          fs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
          smp = $urandom_range(0, 1) ? 16'($urandom)
                                     : 16'(span_lo + $urandom_range(0, span_hi - span_lo));
          send_sample(smp, fs);
        end
      end
      drain();
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    apply_cfg(-16'sd2048, 16'sd2047, 12'd480, 16'd16, 13'd40);
    for (int k = 0; k < 16; k++) begin
      send_sample(16'($urandom_range(0, 4095) - 2048), k == 0);
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Handshake signals only change at rising edges, so the falling edge sees what the next
  // rising edge will accept.
  always @(negedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_dots.size() == 0) begin
        note_error($sformatf("unexpected dot: row %0d index %0d last %0b",
                             $signed(m_axis_tdata[15:0]), m_axis_tdata[27:16], m_axis_tlast));
      end else begin
        want_dot = pending_dots.pop_front();
        dots_checked++;
        if (m_axis_tdata[15:0] !== want_dot.row || m_axis_tdata[27:16] !== want_dot.idx ||
            m_axis_tlast !== want_dot.last) begin
          note_error($sformatf("dot mismatch: expected row %0d index %0d last %0b, got row %0d index %0d last %0b",
                               want_dot.row, want_dot.idx, want_dot.last,
                               $signed(m_axis_tdata[15:0]), m_axis_tdata[27:16], m_axis_tlast));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_row_scaling();
    test_trace_bounds();
    test_random_traces();
    test_steady_stream();
    $display("Sent %0d in-trace samples over %0d register settings; %0d dots checked.",
             items_used, cfg_sets, dots_checked);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out.");
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### sim.f
hdl/stds_pkg.sv
hdl/stds_row_unit.sv
hdl/scope_trace_decimate_scale.sv
tb/testbench.sv
